FILE: sv/usd_pkg.sv
// ----------------------------------------------------------------------------
// usd_pkg: shared types and codes for the UPS status deglitch filter
// Poll and status word layouts, register indexes, power state codes.
// ----------------------------------------------------------------------------
package usd_pkg;

	localparam int CountWidth = 4;
	localparam int CfgIndexWidth = 1;
	localparam int CfgDataWidth = 4;

	typedef logic [CountWidth-1:0] count_t;

	// register indexes on the configuration port
	localparam logic [CfgIndexWidth-1:0] REG_REQUIRED_MATCHES = 1'd0;
	localparam logic [CfgIndexWidth-1:0] REG_MAX_READ_ERRORS = 1'd1;

	localparam count_t RESET_REQUIRED_MATCHES = 4'd3;
	localparam count_t RESET_MAX_READ_ERRORS = 4'd3;

	// published power state codes
	localparam logic [1:0] PWR_FULLY_CHARGED = 2'd0;
	localparam logic [1:0] PWR_CHARGING = 2'd1;
	localparam logic [1:0] PWR_DISCHARGING = 2'd2;

	typedef struct packed {
		logic open_ok;
		logic read_ok;
		logic line_carrier;
		logic line_cts;
		logic line_dsr;
	} poll_t;

	typedef struct packed {
		logic       link_open;
		logic       ups_present;
		logic [1:0] power_state;
		logic       battery_is_low;
		logic       alarm_discharging;
		logic       alarm_battery_low;
	} status_t;

	typedef struct packed {
		count_t required_matches;
		count_t max_read_errors;
	} cfg_t;

endpackage

FILE: sv/usd_in_stage.sv
// ----------------------------------------------------------------------------
// usd_in_stage: poll input register
// Captures one poll word and holds it until the filter consumes it.
// ----------------------------------------------------------------------------
module usd_in_stage import usd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  poll_t in_poll,
	input  logic  advance,
	output logic  valid_s1,
	output poll_t poll_s1
);

	// take a new word when empty or when the held one moves on this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			poll_s1 <= in_poll;
		end
	end

endmodule

FILE: sv/usd_filter.sv
// ----------------------------------------------------------------------------
// usd_filter: link state, match history and published status
// Applies one poll to the filter state and forms the status word.
// ----------------------------------------------------------------------------
module usd_filter import usd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    advance,
	input  poll_t   poll_s1,
	output status_t status
);

	logic       open_q;
	logic [2:0] prev_bits_q;
	logic       prev_valid_q;
	count_t     match_q;
	count_t     error_q;
	logic       dis_rep_q;
	logic       low_rep_q;
	logic       present_q;
	logic [1:0] state_q;
	logic       shown_low_q;

	logic       open_d;
	logic [2:0] prev_bits_d;
	logic       prev_valid_d;
	count_t     match_d;
	count_t     error_d;
	logic       dis_rep_d;
	logic       low_rep_d;
	logic       present_d;
	logic [1:0] state_d;
	logic       shown_low_d;
	logic       alarm_dis;
	logic       alarm_low;

	logic       active;
	logic [2:0] bits;
	count_t     error_inc;
	count_t     match_new;

	assign active = open_q || poll_s1.open_ok;
	assign bits = {poll_s1.line_dsr, poll_s1.line_cts, poll_s1.line_carrier};
	assign error_inc = (error_q < cfg.max_read_errors) ? count_t'(error_q + 4'd1) : error_q;

	always_comb begin
		if (!prev_valid_q || bits != prev_bits_q) begin
			match_new = 4'd1;
		end else if (match_q < cfg.required_matches) begin
			match_new = count_t'(match_q + 4'd1);
		end else begin
			match_new = match_q;
		end
	end

	always_comb begin
		open_d = open_q;
		prev_bits_d = prev_bits_q;
		prev_valid_d = prev_valid_q;
		match_d = match_q;
		error_d = error_q;
		dis_rep_d = dis_rep_q;
		low_rep_d = low_rep_q;
		present_d = present_q;
		state_d = state_q;
		shown_low_d = shown_low_q;
		alarm_dis = 1'b0;
		alarm_low = 1'b0;
		if (active) begin
			open_d = 1'b1;
			if (!poll_s1.read_ok) begin
				match_d = '0;
				prev_bits_d = '0;
				prev_valid_d = 1'b0;
				error_d = error_inc;
				// error limit reached: close and drop everything to reset values
				if (error_inc >= cfg.max_read_errors) begin
					open_d = 1'b0;
					error_d = '0;
					dis_rep_d = 1'b0;
					low_rep_d = 1'b0;
					present_d = 1'b0;
					state_d = PWR_FULLY_CHARGED;
					shown_low_d = 1'b0;
				end
			end else begin
				error_d = '0;
				match_d = match_new;
				prev_bits_d = bits;
				prev_valid_d = 1'b1;
				if (match_new >= cfg.required_matches) begin
					dis_rep_d = poll_s1.line_dsr;
					alarm_dis = poll_s1.line_dsr && !dis_rep_q;
					low_rep_d = poll_s1.line_cts;
					alarm_low = poll_s1.line_cts && !low_rep_q;
					present_d = poll_s1.line_carrier;
					shown_low_d = poll_s1.line_cts;
					if (poll_s1.line_dsr) begin
						state_d = PWR_DISCHARGING;
					end else if (poll_s1.line_cts) begin
						state_d = PWR_CHARGING;
					end else begin
						state_d = PWR_FULLY_CHARGED;
					end
				end
			end
		end
	end

	assign status = '{
		link_open:         open_d,
		ups_present:       present_d,
		power_state:       state_d,
		battery_is_low:    shown_low_d,
		alarm_discharging: alarm_dis,
		alarm_battery_low: alarm_low
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			prev_bits_q <= '0;
			prev_valid_q <= 1'b0;
			match_q <= '0;
			error_q <= '0;
			dis_rep_q <= 1'b0;
			low_rep_q <= 1'b0;
			present_q <= 1'b0;
			state_q <= PWR_FULLY_CHARGED;
			shown_low_q <= 1'b0;
		end else if (advance) begin
			open_q <= open_d;
			prev_bits_q <= prev_bits_d;
			prev_valid_q <= prev_valid_d;
			match_q <= match_d;
			error_q <= error_d;
			dis_rep_q <= dis_rep_d;
			low_rep_q <= low_rep_d;
			present_q <= present_d;
			state_q <= state_d;
			shown_low_q <= shown_low_d;
		end
	end

endmodule

FILE: sv/usd_out_stage.sv
// ----------------------------------------------------------------------------
// usd_out_stage: status result register
// Holds one status word until the receiver takes it.
// ----------------------------------------------------------------------------
module usd_out_stage import usd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid_s1,
	input  status_t status,
	output logic    advance,
	output logic    out_valid,
	input  logic    out_ready,
	output status_t status_s2
);

	// move the held poll on when this register is free or being drained
	assign advance = valid_s1 && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= status;
		end
	end

endmodule

FILE: sv/ups_status_deglitch.sv
// ----------------------------------------------------------------------------
// ups_status_deglitch: UPS status line deglitch filter
// Debounces polled UPS status lines and publishes presence, power state,
// battery level and one-shot alarms.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one poll word: open_ok, read_ok
//   and the carrier, CTS and DSR lines. Output channel (out_valid/out_ready)
//   returns exactly one status word per poll, in order.
//   Configuration: cfg_write with cfg_index/cfg_data sets required_matches
//   (index 0) or max_read_errors (index 1); write only while no poll is in
//   flight.
//   An accepted poll sits in the input register; the state update between
//   the two registers is combinational, and the status register loads its
//   result when free or being drained. Throughput is one poll per cycle
//   while the receiver keeps taking status words.
//   A stalled receiver holds the status register; the input register still
//   takes one more poll, then in_ready drops until the status word is taken.
//   Reset closes the link, clears history and counts, publishes not present,
//   fully charged, battery full, and loads both registers with 3.
// ----------------------------------------------------------------------------
module ups_status_deglitch import usd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CfgIndexWidth-1:0] cfg_index,
	input  logic [CfgDataWidth-1:0]  cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     open_ok,
	input  logic                     read_ok,
	input  logic                     line_carrier,
	input  logic                     line_cts,
	input  logic                     line_dsr,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     link_open,
	output logic                     ups_present,
	output logic [1:0]               power_state,
	output logic                     battery_is_low,
	output logic                     alarm_discharging,
	output logic                     alarm_battery_low
);

	cfg_t    cfg_q;
	poll_t   in_poll;
	poll_t   poll_s1;
	logic    valid_s1;
	logic    advance;
	status_t status;
	status_t status_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.required_matches <= RESET_REQUIRED_MATCHES;
			cfg_q.max_read_errors <= RESET_MAX_READ_ERRORS;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_REQUIRED_MATCHES: cfg_q.required_matches <= cfg_data;
				REG_MAX_READ_ERRORS:  cfg_q.max_read_errors <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_poll = '{
		open_ok:      open_ok,
		read_ok:      read_ok,
		line_carrier: line_carrier,
		line_cts:     line_cts,
		line_dsr:     line_dsr
	};

	usd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_poll  (in_poll),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.poll_s1  (poll_s1)
	);

	usd_filter u_filter (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.advance (advance),
		.poll_s1 (poll_s1),
		.status  (status)
	);

	usd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.status    (status),
		.advance   (advance),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status_s2 (status_s2)
	);

	assign link_open = status_s2.link_open;
	assign ups_present = status_s2.ups_present;
	assign power_state = status_s2.power_state;
	assign battery_is_low = status_s2.battery_is_low;
	assign alarm_discharging = status_s2.alarm_discharging;
	assign alarm_battery_low = status_s2.alarm_battery_low;

endmodule

FILE: sv/usd_checker.sv
// ----------------------------------------------------------------------------
// usd_checker: port-level checks for the UPS status deglitch filter
// Relations between the published status fields and output word stability.
// ----------------------------------------------------------------------------
module usd_checker import usd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       link_open,
	input logic       ups_present,
	input logic [1:0] power_state,
	input logic       battery_is_low,
	input logic       alarm_discharging,
	input logic       alarm_battery_low
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({link_open, ups_present,
			power_state, battery_is_low, alarm_discharging, alarm_battery_low}))
		else $error("status word changed while stalled");

	// closed link always shows the reset status and no alarm
	a_closed_reset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !link_open |-> !ups_present && power_state == PWR_FULLY_CHARGED
			&& !battery_is_low && !alarm_discharging && !alarm_battery_low)
		else $error("closed link shows published status");

	// an alarm goes with the status it announces
	a_alarm_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!alarm_discharging || power_state == PWR_DISCHARGING)
			&& (!alarm_battery_low || battery_is_low))
		else $error("alarm without matching status");

	// battery low never shows as fully charged
	a_low_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && battery_is_low |-> power_state == PWR_CHARGING
			|| power_state == PWR_DISCHARGING)
		else $error("battery low with fully charged state");

endmodule

bind ups_status_deglitch usd_checker u_usd_checker (.*);

FILE: bench/ups_status_deglitch_tb.sv
// ----------------------------------------------------------------------------
// ups_status_deglitch_tb: self-checking bench for the UPS status deglitch filter
// Sends status polls over the valid/ready input channel, predicts each status
// word in step with the block, and checks every word that comes back, with
// random stalls on both sides and register changes between phases.
// ----------------------------------------------------------------------------
module ups_status_deglitch_tb;
	import usd_pkg::*;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_write = 1'b0;
	logic [CfgIndexWidth-1:0] cfg_index = '0;
	logic [CfgDataWidth-1:0]  cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     open_ok = 1'b0;
	logic                     read_ok = 1'b0;
	logic                     line_carrier = 1'b0;
	logic                     line_cts = 1'b0;
	logic                     line_dsr = 1'b0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic                     link_open;
	logic                     ups_present;
	logic [1:0]               power_state;
	logic                     battery_is_low;
	logic                     alarm_discharging;
	logic                     alarm_battery_low;

	// filter model state, updated once per accepted poll
	count_t     need_matches = RESET_REQUIRED_MATCHES;
	count_t     error_limit = RESET_MAX_READ_ERRORS;
	logic       link_up = 1'b0;
	logic [2:0] last_lines = 3'b000;
	logic       last_lines_ok = 1'b0;
	count_t     same_reads = '0;
	count_t     failed_reads = '0;
	logic       dis_flagged = 1'b0;
	logic       low_flagged = 1'b0;
	logic       pub_present = 1'b0;
	logic [1:0] pub_state = PWR_FULLY_CHARGED;
	logic       pub_low = 1'b0;

	status_t status_due[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches = 0;
	int polls_sent = 0;
	int words_checked = 0;
	int link_drops = 0;
	int dis_alarms = 0;
	int low_alarms = 0;
	int settings_used = 0;

	ups_status_deglitch i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.open_ok(open_ok),
		.read_ok(read_ok),
		.line_carrier(line_carrier),
		.line_cts(line_cts),
		.line_dsr(line_dsr),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.link_open(link_open),
		.ups_present(ups_present),
		.power_state(power_state),
		.battery_is_low(battery_is_low),
		.alarm_discharging(alarm_discharging),
		.alarm_battery_low(alarm_battery_low)
	);

	always #6 clk = ~clk;

	initial begin
		#4_000_000;
		$display("ups_status_deglitch test failed");
		$finish;
	end

	function automatic status_t filter_poll(input poll_t p);
		status_t    r;
		logic [2:0] lines;
		logic       active;
		lines = {p.line_dsr, p.line_cts, p.line_carrier};
		active = 1'b1;
		r.alarm_discharging = 1'b0;
		r.alarm_battery_low = 1'b0;
		if (!link_up) begin
			if (p.open_ok)
				link_up = 1'b1;
			else
				active = 1'b0;
		end
		if (active && !p.read_ok) begin
			same_reads = '0;
			last_lines = 3'b000;
			last_lines_ok = 1'b0;
			if (failed_reads < error_limit)
				failed_reads = failed_reads + 1'b1;
			// error limit reached: close and forget everything published
			if (failed_reads >= error_limit) begin
				link_up = 1'b0;
				failed_reads = '0;
				dis_flagged = 1'b0;
				low_flagged = 1'b0;
				pub_present = 1'b0;
				pub_state = PWR_FULLY_CHARGED;
				pub_low = 1'b0;
				link_drops++;
			end
		end else if (active) begin
			failed_reads = '0;
			if (!last_lines_ok || lines != last_lines)
				same_reads = 4'd1;
			else if (same_reads < need_matches)
				same_reads = same_reads + 1'b1;
			if (same_reads >= need_matches) begin
				if (p.line_dsr && !dis_flagged) begin
					r.alarm_discharging = 1'b1;
					dis_alarms++;
				end
				if (p.line_cts && !low_flagged) begin
					r.alarm_battery_low = 1'b1;
					low_alarms++;
				end
				dis_flagged = p.line_dsr;
				low_flagged = p.line_cts;
				pub_present = p.line_carrier;
				if (p.line_dsr)
					pub_state = PWR_DISCHARGING;
				else if (p.line_cts)
					pub_state = PWR_CHARGING;
				else
					pub_state = PWR_FULLY_CHARGED;
				pub_low = p.line_cts;
			end
			last_lines = lines;
			last_lines_ok = 1'b1;
		end
		r.link_open = link_up;
		r.ups_present = pub_present;
		r.power_state = pub_state;
		r.battery_is_low = pub_low;
		return r;
	endfunction

	function automatic poll_t poll_of(input logic o, input logic rd, input logic c,
			input logic l, input logic f);
		poll_t p;
		p.open_ok = o;
		p.read_ok = rd;
		p.line_carrier = c;
		p.line_cts = l;
		p.line_dsr = f;
		return p;
	endfunction

	task automatic note_mismatch(input string what, input logic [7:0] want_v,
			input logic [7:0] got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s at word %0d: expected %0h, got %0h",
				what, words_checked, want_v, got_v);
	endtask

	always @(posedge clk) begin : check_words
		status_t got;
		status_t want;
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && out_valid && out_ready) begin
			got = {link_open, ups_present, power_state, battery_is_low,
				alarm_discharging, alarm_battery_low};
			if (status_due.size() == 0) begin
				note_mismatch("unexpected status word", 8'h00, 8'(got));
			end else begin
				want = status_due.pop_front();
				if (got.link_open !== want.link_open)
					note_mismatch("link_open", 8'(want.link_open), 8'(got.link_open));
				if (got.ups_present !== want.ups_present)
					note_mismatch("ups_present", 8'(want.ups_present),
						8'(got.ups_present));
				if (got.power_state !== want.power_state)
					note_mismatch("power_state", 8'(want.power_state),
						8'(got.power_state));
				if (got.battery_is_low !== want.battery_is_low)
					note_mismatch("battery_is_low", 8'(want.battery_is_low),
						8'(got.battery_is_low));
				if (got.alarm_discharging !== want.alarm_discharging)
					note_mismatch("alarm_discharging", 8'(want.alarm_discharging),
						8'(got.alarm_discharging));
				if (got.alarm_battery_low !== want.alarm_battery_low)
					note_mismatch("alarm_battery_low", 8'(want.alarm_battery_low),
						8'(got.alarm_battery_low));
			end
			words_checked++;
		end
	end

	task automatic send_poll(input poll_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		open_ok <= p.open_ok;
		read_ok <= p.read_ok;
		line_carrier <= p.line_carrier;
		line_cts <= p.line_cts;
		line_dsr <= p.line_dsr;
		do @(posedge clk); while (!in_ready);
		status_due.push_back(filter_poll(p));
		polls_sent++;
	endtask

	// hold the input channel until every predicted word has been taken
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (status_due.size() != 0);
	endtask

	task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input count_t value);
		wait_drained();
		repeat (3) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_REQUIRED_MATCHES)
			need_matches = value;
		else
			error_limit = value;
	endtask

	// reset settings: open failures, error close, publish and alarm re-arm
	task automatic test_link_and_publish();
		send_poll(poll_of(1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
		send_poll(poll_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
		send_poll(poll_of(1'b1, 1'b0, 1'b1, 1'b1, 1'b1));
		repeat (2) send_poll(poll_of(1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
		repeat (3) send_poll(poll_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
		send_poll(poll_of(1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
		repeat (3) send_poll(poll_of(1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
		repeat (3) send_poll(poll_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
		send_poll(poll_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
		repeat (3) send_poll(poll_of(1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
	endtask

	// register extremes, zero limits and limits lowered below running counts
	task automatic test_register_limits();
		write_reg(REG_REQUIRED_MATCHES, 4'd1);
		write_reg(REG_MAX_READ_ERRORS, 4'd1);
		send_poll(poll_of(1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
		send_poll(poll_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
		send_poll(poll_of(1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
		write_reg(REG_REQUIRED_MATCHES, 4'd0);
		write_reg(REG_MAX_READ_ERRORS, 4'd0);
		send_poll(poll_of(1'b1, 1'b1, 1'b0, 1'b1, 1'b1));
		send_poll(poll_of(1'b1, 1'b0, 1'b1, 1'b1, 1'b1));
		write_reg(REG_REQUIRED_MATCHES, 4'd15);
		write_reg(REG_MAX_READ_ERRORS, 4'd15);
		repeat (6) send_poll(poll_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
		write_reg(REG_REQUIRED_MATCHES, 4'd4);
		send_poll(poll_of(1'b1, 1'b1, 1'b1, 1'b1, 1'b0));
		repeat (4) send_poll(poll_of(1'b1, 1'b0, 1'b1, 1'b1, 1'b1));
		write_reg(REG_MAX_READ_ERRORS, 4'd2);
		send_poll(poll_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
	endtask

	// mostly stable line runs long enough to publish, plus short runs,
	// read failure bursts and raw noise
	task automatic test_random_polls(input int count);
		int         left;
		int         run;
		int         kind;
		int         i;
		logic [2:0] lines;
		poll_t      p;
		for (int c = 0; c < 4; c++) begin
			case (settings_used % 6)
				0: begin
					write_reg(REG_REQUIRED_MATCHES, 4'd15);
					write_reg(REG_MAX_READ_ERRORS, 4'd1);
				end
				1: begin
					write_reg(REG_REQUIRED_MATCHES, 4'd1);
					write_reg(REG_MAX_READ_ERRORS, 4'd15);
				end
				2: begin
					write_reg(REG_REQUIRED_MATCHES, 4'd0);
					write_reg(REG_MAX_READ_ERRORS, 4'd0);
				end
				3: begin
					write_reg(REG_REQUIRED_MATCHES, RESET_REQUIRED_MATCHES);
					write_reg(REG_MAX_READ_ERRORS, RESET_MAX_READ_ERRORS);
				end
				4: begin
					write_reg(REG_REQUIRED_MATCHES, 4'd2);
					write_reg(REG_MAX_READ_ERRORS, 4'd4);
				end
				default: begin
					write_reg(REG_REQUIRED_MATCHES, count_t'($urandom_range(15)));
					write_reg(REG_MAX_READ_ERRORS, count_t'($urandom_range(15)));
				end
			endcase
			settings_used++;
			left = count / 4;
			while (left > 0) begin
				kind = $urandom_range(9);
				lines = 3'($urandom_range(7));
				if (kind <= 6)
					run = need_matches + $urandom_range(0, 3);
				else if (kind == 7)
					run = $urandom_range(1, (need_matches > 1) ? need_matches - 1 : 1);
				else if (kind == 8)
					run = $urandom_range(1, error_limit + 1);
				else
					run = $urandom_range(1, 4);
				if (run < 1)
					run = 1;
				for (i = 0; i < run && left > 0; i++) begin
					if (kind == 9) begin
						p = poll_t'($urandom);
					end else begin
						p.open_ok = ($urandom_range(15) != 0);
						p.read_ok = (kind == 8) ? 1'b0 : ($urandom_range(31) != 0);
						{p.line_dsr, p.line_cts, p.line_carrier} = lines;
					end
					send_poll(p);
					left--;
				end
				if ($urandom_range(24) == 0)
					wait_drained();
			end
		end
	endtask

	initial begin : main
		int spins;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 24;
		recv_idle_pct = 71;
		test_link_and_publish();
		test_register_limits();
		test_random_polls(340);

		send_idle_pct = 71;
		recv_idle_pct = 24;
		test_random_polls(340);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_polls(340);

		in_valid <= 1'b0;
		spins = 0;
		while (status_due.size() != 0 && spins < 50000) begin
			@(posedge clk);
			spins++;
		end
		repeat (8) @(posedge clk);
		mismatches += status_due.size();

		$display("covered %0d polls and %0d status words over %0d register settings",
			polls_sent, words_checked, settings_used);
		$display("saw %0d link closes, %0d discharge alarms, %0d battery low alarms",
			link_drops, dis_alarms, low_alarms);
		if (mismatches == 0)
			$display("ups_status_deglitch test passed");
		else
			$display("ups_status_deglitch test failed");
		$finish;
	end

endmodule

FILE: sim.f
sv/usd_pkg.sv
sv/usd_in_stage.sv
sv/usd_filter.sv
sv/usd_out_stage.sv
sv/ups_status_deglitch.sv
sv/usd_checker.sv
bench/ups_status_deglitch_tb.sv
